>>> hdl/quoted_field_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// quoted_field_tokenizer_defines
// assertion macros used by the checker
// ----------------------------------------------------------------------------
`ifndef QUOTED_FIELD_TOKENIZER_DEFINES_SVH
`define QUOTED_FIELD_TOKENIZER_DEFINES_SVH

// same-cycle implication
`define QFT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qft assertion failed");

// next-cycle implication
`define QFT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qft assertion failed");

`endif

>>> hdl/qft_pkg.sv
// ----------------------------------------------------------------------------
// qft_pkg
// types, codes and helpers shared by the tokenizer modules
// ----------------------------------------------------------------------------
`default_nettype none

package qft_pkg;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_FEND = 2'd1;
    localparam logic [1:0] KIND_TEND = 2'd2;

    localparam logic [7:0] QUOTE_CH = 8'h27;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // results of one request, in emission order: pre_end, char, post_end, text_end
    typedef struct packed {
        logic       pre_end;
        logic       has_char;
        logic [7:0] ch;
        logic       post_end;
        logic       text_end;
    } plan_t;

    typedef struct packed {
        logic valid;
        logic full;
    } qstat_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    function automatic logic [3:0] plan_mask(input plan_t p);
        return {p.text_end, p.post_end, p.has_char, p.pre_end};
    endfunction

endpackage

`default_nettype wire

>>> hdl/qft_front.sv
// ----------------------------------------------------------------------------
// qft_front
// accepts bytes, runs the scan state and builds a result plan per byte
// ----------------------------------------------------------------------------
`default_nettype none

module qft_front
    import qft_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire qstat_t     q_stat,
    output logic            q_push,
    output plan_t           q_plan
);

    localparam logic [1:0] ST_BETWEEN    = 2'd0;
    localparam logic [1:0] ST_PLAIN      = 2'd1;
    localparam logic [1:0] ST_QUOTED     = 2'd2;
    localparam logic [1:0] ST_QUOTE_SEEN = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [1:0] scan_next;
    logic       accept;
    logic       sp;
    logic       qt;
    plan_t      plan;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign sp       = is_space(s_tdata);
    assign qt       = (s_tdata == QUOTE_CH);

    always_comb begin
        plan          = '0;
        plan.ch       = s_tdata;
        scan_next     = state_reg;
        unique case (state_reg)
            ST_BETWEEN: begin
                if (sp) begin
                    scan_next = ST_BETWEEN;
                end else if (qt) begin
                    scan_next = ST_QUOTED;
                end else begin
                    plan.has_char = 1'b1;
                    scan_next     = ST_PLAIN;
                end
            end
            ST_PLAIN: begin
                if (sp) begin
                    plan.pre_end = 1'b1;
                    scan_next    = ST_BETWEEN;
                end else begin
                    plan.has_char = 1'b1;
                end
            end
            ST_QUOTED: begin
                if (qt) begin
                    scan_next = ST_QUOTE_SEEN;
                end else begin
                    plan.has_char = 1'b1;
                end
            end
            default: begin
                if (qt) begin
                    plan.has_char = 1'b1;
                    scan_next     = ST_QUOTED;
                end else if (sp) begin
                    plan.pre_end = 1'b1;
                    scan_next    = ST_BETWEEN;
                end else begin
                    plan.pre_end  = 1'b1;
                    plan.has_char = 1'b1;
                    scan_next     = ST_PLAIN;
                end
            end
        endcase
        if (!plan.has_char) begin
            plan.ch = 8'd0;
        end
        state_next = scan_next;
        if (s_tlast) begin
            plan.post_end = (scan_next != ST_BETWEEN);
            plan.text_end = 1'b1;
            state_next    = ST_BETWEEN;
        end
    end

    assign q_plan = plan;
    assign q_push = accept && (plan_mask(plan) != 4'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BETWEEN;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/qft_queue.sv
// ----------------------------------------------------------------------------
// qft_queue
// short plan queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module qft_queue
    import qft_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire plan_t push_plan,
    input  wire logic  pop,
    output plan_t      head,
    output qstat_t     stat
);

    plan_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_plan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/qft_back.sv
// ----------------------------------------------------------------------------
// qft_back
// walks the head plan into the output register, one result per unstalled cycle
// ----------------------------------------------------------------------------
`default_nettype none

module qft_back
    import qft_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire plan_t head,
    input  wire qstat_t q_stat,
    output logic       pop,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [7:0] m_tdata,
    output logic [1:0] m_tuser,
    output logic       m_tlast
);

    logic [3:0] done_reg;
    logic [3:0] done_next;
    logic [3:0] remain;
    logic [3:0] sel;
    logic       load;
    logic       fin;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic [1:0] kind_reg;
    logic       last_reg;
    logic [7:0] data_next;
    logic [1:0] kind_next;

    assign remain = plan_mask(head) & ~done_reg;
    assign sel    = remain & (~remain + 4'd1);
    assign fin    = ((remain & ~sel) == 4'd0);
    assign load   = q_stat.valid && (!valid_reg || m_tready);
    assign pop    = load && fin;

    always_comb begin
        data_next = 8'd0;
        kind_next = KIND_FEND;
        case (sel)
            4'b0010: begin
                kind_next = KIND_CHAR;
                data_next = head.ch;
            end
            4'b1000: kind_next = KIND_TEND;
            default: kind_next = KIND_FEND;
        endcase
        done_next = done_reg;
        if (load) begin
            done_next = fin ? 4'd0 : (done_reg | sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
            kind_reg <= kind_next;
            last_reg <= fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            done_reg  <= 4'd0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> hdl/quoted_field_tokenizer.sv
// path: an accepted request reaches its first result through a queue write
// then the output register
// throughput: one request per cycle while each yields at most one result and
// the receiver does not stall; a request yielding several results holds the
// single-result output stage, a two-entry plan queue absorbing bursts
// reset: synchronous active-low aresetn returns the scanner to between fields
// ----------------------------------------------------------------------------
// quoted_field_tokenizer
// splits text bytes into fields with single-quoted field support
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_field_tokenizer
    import qft_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic [1:0]      m_tuser,   // [1:0] kind
    output logic            m_tlast
);

    qstat_t q_stat;
    plan_t  push_plan;
    plan_t  head;
    logic   push;
    logic   pop;

    qft_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .q_push   (push),
        .q_plan   (push_plan)
    );

    qft_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_plan (push_plan),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    qft_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> hdl/qft_checker.sv
// ----------------------------------------------------------------------------
// qft_checker
// port-level checks on the tokenizer result stream
// ----------------------------------------------------------------------------
`default_nettype none
`include "quoted_field_tokenizer_defines.svh"

module qft_checker
    import qft_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);

    logic m_stall;
    logic kind_ok;
    logic not_char;
    logic is_tend;

    assign m_stall  = m_tvalid && !m_tready;
    assign kind_ok  = (m_tuser == KIND_CHAR) || (m_tuser == KIND_FEND) || (m_tuser == KIND_TEND);
    assign not_char = m_tvalid && (m_tuser != KIND_CHAR);
    assign is_tend  = m_tvalid && (m_tuser == KIND_TEND);

    `QFT_ASSERT_IMPL(a_kind_range, aclk, aresetn, m_tvalid, kind_ok)
    `QFT_ASSERT_IMPL(a_char_zero, aclk, aresetn, not_char, m_tdata == 8'd0)
    `QFT_ASSERT_IMPL(a_tend_last, aclk, aresetn, is_tend, m_tlast)
    `QFT_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_stall, m_tvalid && $stable(m_tdata))
    `QFT_ASSERT_NEXT(a_hold_user, aclk, aresetn, m_stall, $stable(m_tuser) && $stable(m_tlast))

endmodule

bind quoted_field_tokenizer qft_checker u_chk (.*);

`default_nettype wire

>>> bench/quoted_field_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// quoted_field_tokenizer_tb
// drives byte texts into the tokenizer and checks every emitted token against
// a cycle-free model of the field scanner kept in a small scoreboard; random
// gaps, receiver stalls, one long receiver hold and one drain pause included
// ----------------------------------------------------------------------------
module quoted_field_tokenizer_tb;
    import qft_pkg::*;

    localparam int LIMIT        = 200000;
    localparam int RANDOM_BYTES = 225;
    localparam int LONG_HOLD    = 80;

    typedef enum logic [1:0] {
        SCAN_GAP,
        SCAN_PLAIN,
        SCAN_QUOTED,
        SCAN_QUOTE_PEND
    } scan_e;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       run_last;
    } token_t;

    class field_scoreboard;
        scan_e  scan;
        token_t pending_tokens[$];
        int     errors;

        function new();
            scan   = SCAN_GAP;
            errors = 0;
        endfunction

        static function logic is_sep(logic [7:0] c);
            return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
        endfunction

        function int pending();
            return pending_tokens.size();
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            token_t batch[$];
            logic   sep;
            sep = is_sep(c);
            case (scan)
                SCAN_GAP: begin
                    if (!sep) begin
                        if (c == QUOTE_CH) begin
                            scan = SCAN_QUOTED;
                        end else begin
                            batch.push_back(token_t'{KIND_CHAR, c, 1'b0});
                            scan = SCAN_PLAIN;
                        end
                    end
                end
                SCAN_PLAIN: begin
                    if (sep) begin
                        batch.push_back(token_t'{KIND_FEND, 8'h00, 1'b0});
                        scan = SCAN_GAP;
                    end else begin
                        batch.push_back(token_t'{KIND_CHAR, c, 1'b0});
                    end
                end
                SCAN_QUOTED: begin
                    if (c == QUOTE_CH) begin
                        scan = SCAN_QUOTE_PEND;
                    end else begin
                        batch.push_back(token_t'{KIND_CHAR, c, 1'b0});
                    end
                end
                default: begin
                    if (c == QUOTE_CH) begin
                        batch.push_back(token_t'{KIND_CHAR, QUOTE_CH, 1'b0});
                        scan = SCAN_QUOTED;
                    end else if (sep) begin
                        batch.push_back(token_t'{KIND_FEND, 8'h00, 1'b0});
                        scan = SCAN_GAP;
                    end else begin
                        batch.push_back(token_t'{KIND_FEND, 8'h00, 1'b0});
                        batch.push_back(token_t'{KIND_CHAR, c, 1'b0});
                        scan = SCAN_PLAIN;
                    end
                end
            endcase
            if (last) begin
                if (scan != SCAN_GAP) begin
                    batch.push_back(token_t'{KIND_FEND, 8'h00, 1'b0});
                end
                batch.push_back(token_t'{KIND_TEND, 8'h00, 1'b0});
                scan = SCAN_GAP;
            end
            if (batch.size() > 0) begin
                batch[batch.size() - 1].run_last = 1'b1;
            end
            foreach (batch[i]) begin
                pending_tokens.push_back(batch[i]);
            end
        endfunction

        function void check_token(logic [1:0] kind, logic [7:0] ch, logic last);
            token_t want;
            if (pending_tokens.size() == 0) begin
                $error("token with none expected: kind %0d char %02h last %0d", kind, ch, last);
                errors++;
                return;
            end
            want = pending_tokens.pop_front();
            if (kind !== want.kind) begin
                $error("kind: expected %0d got %0d", want.kind, kind);
                errors++;
            end
            if (ch !== want.ch) begin
                $error("out_char: expected %02h got %02h", want.ch, ch);
                errors++;
            end
            if (last !== want.run_last) begin
                $error("run_last: expected %0d got %0d", want.run_last, last);
                errors++;
            end
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_char
    logic [1:0] m_tuser;            // [1:0] kind
    logic       m_tlast;

    field_scoreboard scoreboard = new();

    logic       tx_eager  = 1'b0;
    logic       rx_eager  = 1'b0;
    int         hold_asks = 0;
    int         hold_seen = 0;
    int         stall_left = 0;
    int         sent      = 0;
    int         cycles    = 0;
    logic [7:0] text_buf[$];

    quoted_field_tokenizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("quoted_field_tokenizer_tb NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin : rx_side
        int draw;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                scoreboard.check_token(m_tuser, m_tdata, m_tlast);
            end
            if (hold_asks != hold_seen) begin
                hold_seen  <= hold_asks;
                stall_left <= LONG_HOLD;
                m_tready   <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                draw = rx_eager ? 0 : $urandom_range(0, 15);
                if (draw == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready   <= 1'b0;
                    stall_left <= draw;
                end
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= (stall_left == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        scoreboard.note_byte(c, last);
        sent++;
    endtask

    task automatic drain_tokens();
        while (scoreboard.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 3))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0D;
            default: return 8'h0A;
        endcase
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == QUOTE_CH || field_scoreboard::is_sep(c));
        return c;
    endfunction

    // mostly well-formed fields, some raw noise heavy in quotes and separators
    task automatic build_text();
        text_buf.delete();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 3))
                    0: text_buf.push_back(QUOTE_CH);
                    1: text_buf.push_back(ws_char());
                    default: text_buf.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 2)) text_buf.push_back(ws_char());
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(1, 4)) text_buf.push_back(word_char());
                end else begin
                    text_buf.push_back(QUOTE_CH);
                    repeat ($urandom_range(0, 4)) begin
                        case ($urandom_range(0, 4))
                            0: begin
                                text_buf.push_back(QUOTE_CH);
                                text_buf.push_back(QUOTE_CH);
                            end
                            1: text_buf.push_back(ws_char());
                            default: text_buf.push_back(word_char());
                        endcase
                    end
                    if ($urandom_range(0, 7) != 0) begin
                        text_buf.push_back(QUOTE_CH);
                        if ($urandom_range(0, 2) == 0) begin
                            text_buf.push_back(word_char());
                        end
                    end
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                text_buf.push_back(ws_char());
            end
        end
    endtask

    initial begin
        int texts;
        int first_random;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(QUOTE_CH, 1'b0);
        send_byte("a", 1'b0);
        send_byte(QUOTE_CH, 1'b0);
        send_byte(QUOTE_CH, 1'b0);   // doubled quote
        send_byte(8'h0D, 1'b0);      // whitespace kept inside quotes
        send_byte(QUOTE_CH, 1'b0);
        send_byte(8'h0A, 1'b0);      // closing quote then whitespace
        send_byte(QUOTE_CH, 1'b0);
        send_byte("b", 1'b0);
        send_byte(QUOTE_CH, 1'b0);
        send_byte("c", 1'b1);        // closing quote then char, on the final byte
        send_byte(QUOTE_CH, 1'b0);
        send_byte(QUOTE_CH, 1'b0);
        send_byte(8'h20, 1'b0);      // empty quoted field
        send_byte(QUOTE_CH, 1'b0);
        send_byte("d", 1'b1);        // unterminated quote
        send_byte(QUOTE_CH, 1'b1);   // lone quote as final byte
        send_byte(8'h20, 1'b1);
        send_byte(QUOTE_CH, 1'b0);
        send_byte(QUOTE_CH, 1'b1);   // empty quoted field at end of text

        texts        = 0;
        first_random = sent;
        while (sent < first_random + RANDOM_BYTES) begin
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager <= ($urandom_range(0, 3) == 0);
            if (texts == 4) begin
                tx_eager = 1'b1;
                hold_asks <= hold_asks + 1;
            end
            if (texts == 20) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                drain_tokens();
            end
            build_text();
            foreach (text_buf[i]) begin
                send_byte(text_buf[i], i == text_buf.size() - 1);
            end
            texts++;
        end

        s_tvalid <= 1'b0;
        drain_tokens();
        repeat (20) @(posedge aclk);
        if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
            $display("quoted_field_tokenizer_tb OK");
        end else begin
            $display("quoted_field_tokenizer_tb NOT OK");
        end
        $finish;
    end

endmodule
